@@ rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the hair cell transmitter block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define IHC_ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define IHC_ASSERT(label, prop) \
  `IHC_ASSERT_IMPL(label, clk_i, rst_ni, prop)
`else
`define IHC_ASSERT_IMPL(label, clk, rst_n, prop)
`define IHC_ASSERT(label, prop)
`endif
`endif

@@ rtl/ihc_pkg.sv @@
// Package with the constants, types and helpers of the hair cell transmitter block.
`default_nettype none
package ihc_pkg;

  localparam int CHANNELS = 64;
  localparam int ADDR_W   = $clog2(CHANNELS);
  localparam int CH_W     = 6;
  localparam int SMP_W    = 24;
  localparam int POOL_W   = 32;
  localparam int MEM_W    = 3 * POOL_W;

  // Spontaneous cleft level and the resting pool contents, Q0.32.
  localparam logic [63:0] SPONT = (64'd5050000 << 32) / 64'd3898547000;
  localparam logic [31:0] CLEFT_RST = SPONT[31:0];
  localparam logic [63:0] FREE_RST64 = SPONT * 64'd2769400 / 64'd10000;
  localparam logic [31:0] FREE_RST = FREE_RST64[31:0];
  localparam logic [63:0] STORE_RST64 = SPONT * 64'd658000 / 64'd6631;
  localparam logic [31:0] STORE_RST = STORE_RST64[31:0];
  localparam logic [63:0] SP_RATE64 = (64'd50000 * SPONT) >> 16;
  localparam logic [32:0] SP_RATE = SP_RATE64[32:0];

  localparam logic signed [24:0] OFFSET_A = 25'sd327680;
  localparam logic [24:0] SATUR_B  = 25'd19660800;
  localparam logic [32:0] SCALE_H  = 33'd50000;
  localparam logic [32:0] ONE_Q32  = 33'h1_0000_0000;

  typedef enum logic [2:0] {
    CFG_RELEASE   = 3'd0,
    CFG_REPLENISH = 3'd1,
    CFG_LOSS      = 3'd2,
    CFG_REUPTAKE  = 3'd3,
    CFG_REPROCESS = 3'd4,
    CFG_SUBTRACT  = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_MUL,
    ST_UPD,
    ST_RATE,
    ST_RWAIT,
    ST_FIN
  } state_e;

  // Multiply sequence steps on the shared multiplier.
  typedef enum logic [2:0] {
    MUL_KT   = 3'd0,
    MUL_REP  = 3'd1,
    MUL_LOSS = 3'd2,
    MUL_REUP = 3'd3,
    MUL_REPR = 3'd4,
    MUL_EJ   = 3'd5,
    MUL_LAST = 3'd6
  } mul_step_e;

  // Divider handshake toward the sequencer.
  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } div_res_t;

  // Clamp a signed pool update into [0, 2^32-1].
  function automatic logic [31:0] sat_pool(input logic signed [34:0] v);
    logic [31:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > 35'sh0_FFFF_FFFF) begin
      r = '1;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/ihc_divider.sv @@
// Bit-serial restoring divider for the release permeability ratio lim * 2^32 / (lim + B).
`default_nettype none
module ihc_divider
  import ihc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [23:0] lim_i,
  output div_res_t         res_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [24:0] rem_q, rem_d;
  logic [24:0] div_q, div_d;
  logic [31:0] quot_q, quot_d;
  logic [25:0] shifted;
  logic [25:0] diff;

  // One quotient bit per cycle.
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    div_d   = div_q;
    quot_d  = quot_q;
    shifted = {rem_q, 1'b0};
    diff    = shifted - {1'b0, div_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = {1'b0, lim_i};
      div_d  = {1'b0, lim_i} + SATUR_B;
      quot_d = '0;
    end else if (busy_q) begin
      if (shifted >= {1'b0, div_q}) begin
        rem_d  = diff[24:0];
        quot_d = {quot_q[30:0], 1'b1};
      end else begin
        rem_d  = shifted[24:0];
        quot_d = {quot_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    div_q  <= div_d;
    quot_q <= quot_d;
  end

  assign res_o.done = done_q;
  assign res_o.quot = quot_q;

endmodule
`default_nettype wire

@@ rtl/ihc_mul.sv @@
// Shared registered multiplier used for every product of the pool update.
`default_nettype none
module ihc_mul
  import ihc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic [32:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [63:0] prod_o
);

  logic [64:0] full;
  logic [63:0] prod_q;

  // Operands never exceed 2^32 times 2^32-1, so 64 bits hold the product.
  assign full = a_i * {1'b0, b_i};

  always_ff @(posedge clk_i) begin
    prod_q <= full[63:0];
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

@@ rtl/ihc_state_mem.sv @@
// Per-channel pool storage: free pool, cleft and reprocessing store in one word.
`default_nettype none
module ihc_state_mem
  import ihc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [MEM_W-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [MEM_W-1:0]  rdata_o
);

  logic [MEM_W-1:0] mem [CHANNELS];
  logic [MEM_W-1:0] rdata_q;

  // Single write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ rtl/inner_hair_cell_transmitter_model_unit.sv @@
// Top level of the inner hair cell transmitter block: sequencer, registers and datapath.
//
// Usage: an input transaction carries a channel number and a signed Q8.16
// filterbank sample on channel_i and sample_i with in_valid_i / in_ready_o.
// The channel's three transmitter pools advance by one sample period and one
// output transaction returns channel_out_o and the Q16.16 firing rate rate_o
// on out_valid_o / out_ready_i.
// From input acceptance to out_valid_o an item passes the serial divide for
// the permeability ratio and seven products that run one after another
// through a single multiplier. One item is in flight at a time: a new input
// is accepted only once the sequencer is back in idle. Channels beyond the
// channel count return rate 0 and change no state.
// Configuration writes on cfg_valid_i / cfg_ready_o are taken at any time and
// must be issued only while the block is idle.
// Reset: all pools read as their resting values (per-channel valid bits are
// cleared), registers take their defaults; no clearing pass is needed.
// Stall: a finished result waits in the output register; the next input is
// accepted meanwhile, and its result is held back until the register frees.
`default_nettype none
`include "assert_macros.svh"
module inner_hair_cell_transmitter_model_unit
  import ihc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [CH_W-1:0]   channel_i,
  input  wire logic [SMP_W-1:0]  sample_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [CH_W-1:0]   channel_out_o,
  output logic      [31:0]       rate_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [2:0]        cfg_index_i,
  input  wire logic [31:0]       cfg_data_i
);

  state_e state_q, state_d;
  mul_step_e step_q, step_d;

  logic [31:0] release_q, replenish_q, loss_q, reuptake_q, reprocess_q;
  logic        subtract_q;

  logic [CH_W-1:0] ch_q;
  logic [23:0]     lim_q;
  logic            rng_q;
  logic            vld_rd_q;
  logic [CHANNELS-1:0] vld_q;

  logic [31:0] pq_q, pc_q, pw_q;
  logic [31:0] kt_q, rep_q, loss_p_q, reup_q, repr_q, ej_q, newc_q;
  logic [31:0] res_q;
  logic        out_valid_q;
  logic [CH_W-1:0] chout_q;
  logic [31:0] rate_q;

  logic              accept;
  logic              div_start;
  div_res_t          div_res;
  logic [32:0]       mul_a;
  logic [31:0]       mul_b;
  logic [63:0]       prod;
  logic [MEM_W-1:0]  rdata;
  logic              mem_we;
  logic [MEM_W-1:0]  wdata;
  logic signed [24:0] lim_s;
  logic signed [34:0] sum_q, sum_c, sum_w;
  logic [31:0]       nq, nc, nw;
  logic [32:0]       scaled;
  logic [32:0]       rate_sub;
  logic [31:0]       rate_fin;
  logic              load_out;
  logic [ADDR_W-1:0] ch_addr;
  logic [ADDR_W-1:0] in_addr;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign ch_addr     = ch_q[ADDR_W-1:0];
  assign in_addr     = channel_i[ADDR_W-1:0];

  // Offset the sample; the clamp at zero is applied when lim_q is registered.
  assign lim_s = {sample_i[SMP_W-1], sample_i} + OFFSET_A;

  ihc_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .lim_i   (lim_q),
    .res_o   (div_res)
  );

  ihc_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  ihc_state_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (ch_addr),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (in_addr),
    .rdata_o (rdata)
  );

  // Pool updates from the registered products.
  assign sum_q = $signed({3'b0, pq_q}) + $signed({3'b0, rep_q})
               - $signed({3'b0, ej_q}) + $signed({3'b0, repr_q});
  assign sum_c = $signed({3'b0, pc_q}) + $signed({3'b0, ej_q})
               - $signed({3'b0, loss_p_q}) - $signed({3'b0, reup_q});
  assign sum_w = $signed({3'b0, pw_q}) + $signed({3'b0, reup_q})
               - $signed({3'b0, repr_q});
  assign nq    = sat_pool(sum_q);
  assign nc    = sat_pool(sum_c);
  assign nw    = sat_pool(sum_w);
  assign wdata = {nq, nc, nw};

  // Rate scaling, optional spontaneous subtraction and saturation.
  assign scaled   = prod[48:16];
  assign rate_sub = (scaled > SP_RATE) ? (scaled - SP_RATE) : '0;
  always_comb begin
    if (subtract_q) begin
      rate_fin = (rate_sub[32]) ? '1 : rate_sub[31:0];
    end else begin
      rate_fin = (scaled[32]) ? '1 : scaled[31:0];
    end
  end

  // Sequencer: next state and shared-unit operand selection.
  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    div_start = 1'b0;
    mem_we    = 1'b0;
    load_out  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (rng_q) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_d = ST_MUL;
          step_d  = MUL_KT;
        end
      end
      ST_MUL: begin
        case (step_q)
          MUL_KT: begin
            mul_a = {1'b0, release_q};
            mul_b = div_res.quot;
          end
          MUL_REP: begin
            mul_a = ONE_Q32 - {1'b0, pq_q};
            mul_b = replenish_q;
          end
          MUL_LOSS: begin
            mul_a = {1'b0, loss_q};
            mul_b = pc_q;
          end
          MUL_REUP: begin
            mul_a = {1'b0, reuptake_q};
            mul_b = pc_q;
          end
          MUL_REPR: begin
            mul_a = {1'b0, reprocess_q};
            mul_b = pw_q;
          end
          MUL_EJ: begin
            mul_a = {1'b0, kt_q};
            mul_b = pq_q;
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
        if (step_q == MUL_LAST) begin
          state_d = ST_UPD;
        end else begin
          step_d = mul_step_e'(step_q + 3'd1);
        end
      end
      ST_UPD: begin
        mem_we  = 1'b1;
        state_d = ST_RATE;
      end
      ST_RATE: begin
        mul_a   = SCALE_H;
        mul_b   = newc_q;
        state_d = ST_RWAIT;
      end
      ST_RWAIT: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= MUL_KT;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (mem_we) begin
        vld_q[ch_addr] <= 1'b1;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      release_q   <= 32'd193273528;
      replenish_q <= 32'd491767;
      loss_q      <= 32'd243458397;
      reuptake_q  <= 32'd640822302;
      reprocess_q <= 32'd6457780;
      subtract_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_RELEASE:   release_q   <= cfg_data_i;
        CFG_REPLENISH: replenish_q <= cfg_data_i;
        CFG_LOSS:      loss_q      <= cfg_data_i;
        CFG_REUPTAKE:  reuptake_q  <= cfg_data_i;
        CFG_REPROCESS: reprocess_q <= cfg_data_i;
        CFG_SUBTRACT:  subtract_q  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q     <= channel_i;
      lim_q    <= lim_s[24] ? '0 : lim_s[23:0];
      rng_q    <= ({26'd0, channel_i} < CHANNELS);
      vld_rd_q <= vld_q[in_addr];
    end
    if (state_q == ST_LOAD) begin
      pq_q  <= vld_rd_q ? rdata[3*POOL_W-1:2*POOL_W] : FREE_RST;
      pc_q  <= vld_rd_q ? rdata[2*POOL_W-1:POOL_W]   : CLEFT_RST;
      pw_q  <= vld_rd_q ? rdata[POOL_W-1:0]          : STORE_RST;
      res_q <= '0;
    end
    if (state_q == ST_MUL) begin
      case (step_q)
        MUL_REP:  kt_q     <= prod[63:32];
        MUL_LOSS: rep_q    <= prod[63:32];
        MUL_REUP: loss_p_q <= prod[63:32];
        MUL_REPR: reup_q   <= prod[63:32];
        MUL_EJ:   repr_q   <= prod[63:32];
        MUL_LAST: ej_q     <= prod[63:32];
        default: begin
        end
      endcase
    end
    if (state_q == ST_UPD) begin
      newc_q <= nc;
    end
    if (state_q == ST_RWAIT) begin
      res_q <= rate_fin;
    end
    if (load_out) begin
      chout_q <= ch_q;
      rate_q  <= res_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign channel_out_o = chout_q;
  assign rate_o        = rate_q;

  `IHC_ASSERT(a_busy_after_accept, accept |=> !in_ready_o)
  `IHC_ASSERT(a_out_from_fin, $rose(out_valid_o) |-> $past(state_q == ST_FIN))
  `IHC_ASSERT(a_div_done_in_div, div_res.done |-> (state_q == ST_DIV))

endmodule
`default_nettype wire
